FILE: rtl/core/mbc1_pkg.sv
`default_nettype none
package mbc1_pkg;

    // bus operation codes
    typedef enum logic [1:0] {
        OP_CTRL_WRITE = 2'd0,
        OP_ROM_READ   = 2'd1,
        OP_RAM_READ   = 2'd2,
        OP_RAM_WRITE  = 2'd3
    } op_t;

    // memory target codes
    localparam logic [1:0] TGT_NONE = 2'd0;
    localparam logic [1:0] TGT_ROM  = 2'd1;
    localparam logic [1:0] TGT_RAM  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_ROM_MASK    = 2'd0;
    localparam logic [1:0] REG_RAM_MASK    = 2'd1;
    localparam logic [1:0] REG_RAM_PRESENT = 2'd2;

    // control write regions, address bits 14:13
    localparam logic [1:0] REGION_RAM_ENABLE = 2'd0;
    localparam logic [1:0] REGION_ROM_BANK   = 2'd1;
    localparam logic [1:0] REGION_RAM_BANK   = 2'd2;
    localparam logic [1:0] REGION_MODEL      = 2'd3;

    localparam logic [7:0]  RAM_ENABLE_KEY       = 8'h0A;
    localparam logic [15:0] MULTICART_PROBE_ADDR = 16'h2100;
    localparam logic [7:0]  ROM_BANK_LOW_MASK    = 8'h1F;

    // multicart flag values
    localparam logic [1:0] MULTICART_NONE   = 2'd0;
    localparam logic [1:0] MULTICART_PROBED = 2'd1;
    localparam logic [1:0] MULTICART_NO_RAM = 2'd2;
    localparam logic [1:0] MULTICART_ACTIVE = 2'd3;

    localparam logic [21:0] ROM_WINDOW_SIZE = 22'h004000;

    localparam logic [21:0] ROM_MASK_RESET    = 22'h007FFF;
    localparam logic [14:0] RAM_MASK_RESET    = 15'h1FFF;
    localparam logic        RAM_PRESENT_RESET = 1'b1;

    typedef struct packed {
        op_t         operation;
        logic [15:0] bus_address;
        logic [7:0]  bus_data;
    } mbc_req_t;

    typedef struct packed {
        logic [1:0]  target;
        logic [21:0] phys_address;
        logic        mem_write;
        logic [7:0]  mem_data;
        logic        force_ff;
    } mbc_rsp_t;

    typedef struct packed {
        logic [21:0] rom_mask;
        logic [14:0] ram_mask;
        logic        ram_present;
    } mbc_cfg_t;

    typedef struct packed {
        logic        ram_enabled;
        logic [7:0]  rom_bank;
        logic [1:0]  ram_bank;
        logic        model_select;
        logic [1:0]  rom_high_bits;
        logic [14:0] ram_bank_offset;
        logic [1:0]  multicart_flag;
        logic [21:0] rom_low_base;
        logic [21:0] rom_high_base;
        logic [14:0] ram_window_base;
    } mbc_state_t;

    localparam mbc_state_t STATE_RESET = '{
        ram_enabled:     1'b0,
        rom_bank:        8'd1,
        ram_bank:        2'd0,
        model_select:    1'b0,
        rom_high_bits:   2'd0,
        ram_bank_offset: 15'd0,
        multicart_flag:  MULTICART_NONE,
        rom_low_base:    22'd0,
        rom_high_base:   ROM_WINDOW_SIZE,
        ram_window_base: 15'd0
    };

endpackage
`default_nettype wire

FILE: rtl/core/mbc1_stream_if.sv
`default_nettype none
interface mbc1_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/mbc1_bank_controller_top.sv
`default_nettype none
// cartridge bank controller: translates cpu bus accesses into rom/ram byte addresses
// an accepted transaction goes into the input register, then into the result register
// throughput: one transaction per cycle through both registers, unless rsp.ready stalls
// control writes update the bank state in the same pass, so the next transaction sees them
// reset: asynchronous active low; bank state returns to rom bank 1, high window 0x4000,
// ram disabled, masks 0x7fff / 0x1fff, ram present; pipeline empties
module mbc1_bank_controller_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    mbc1_stream_if.sink      req,
    mbc1_stream_if.source    rsp,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import mbc1_pkg::*;

    // configuration registers
    logic [21:0] rom_mask_reg;
    logic [14:0] ram_mask_reg;
    logic        ram_present_reg;
    mbc_cfg_t    cfg;
    logic        cfg_write;

    // input stage and result stage
    logic        s1_valid_reg;
    logic        s1_valid_next;
    mbc_req_t    s1_req_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    mbc_rsp_t    out_rsp_reg;
    mbc_rsp_t    rsp_comb;
    logic        accept;
    logic        advance;

    mbc_state_t  state;
    logic        bank_wr;
    logic        ram_ok;
    logic [14:0] ram_phys;
    logic [21:0] rom_base;

    assign cfg.rom_mask    = rom_mask_reg;
    assign cfg.ram_mask    = ram_mask_reg;
    assign cfg.ram_present = ram_present_reg;

    // apb: no wait states, write completes in the access phase
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rom_mask_reg    <= ROM_MASK_RESET;
            ram_mask_reg    <= RAM_MASK_RESET;
            ram_present_reg <= RAM_PRESENT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                REG_ROM_MASK:    rom_mask_reg    <= pwdata[21:0];
                REG_RAM_MASK:    ram_mask_reg    <= pwdata[14:0];
                REG_RAM_PRESENT: ram_present_reg <= pwdata[0];
                default:         ram_present_reg <= ram_present_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_ROM_MASK:    prdata = {10'd0, rom_mask_reg};
            REG_RAM_MASK:    prdata = {17'd0, ram_mask_reg};
            REG_RAM_PRESENT: prdata = {31'd0, ram_present_reg};
            default:         prdata = '0;
        endcase
    end

    // pipeline handshake: the input stage moves on whenever the result
    // register is empty or its transaction is being taken
    assign advance   = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !s1_valid_reg || advance;
    assign accept    = req.valid && req.ready;

    assign s1_valid_next  = accept || (s1_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !rsp.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_req_reg <= req.payload;
        end
        if (advance)
        begin
            out_rsp_reg <= rsp_comb;
        end
    end

    // control writes at or above 0x8000 are ignored
    assign bank_wr = advance && (s1_req_reg.operation == OP_CTRL_WRITE)
                     && !s1_req_reg.bus_address[15];

    mbc1_bank_regs u_bank_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .wr_en       (bank_wr),
        .bus_address (s1_req_reg.bus_address),
        .bus_data    (s1_req_reg.bus_data),
        .cfg         (cfg),
        .state       (state)
    );

    // address translation from the current window bases
    assign ram_ok   = state.ram_enabled && ram_present_reg;
    // ram accesses only use the low 13 address bits, wrapped by the ram size
    assign ram_phys = (state.ram_window_base + {2'b00, s1_req_reg.bus_address[12:0]})
                      & ram_mask_reg;
    // bit 14 picks the switchable high window
    assign rom_base = s1_req_reg.bus_address[14] ? state.rom_high_base : state.rom_low_base;

    always_comb
    begin
        rsp_comb = '0;
        case (s1_req_reg.operation)
            OP_ROM_READ:
            begin
                if (!s1_req_reg.bus_address[15])
                begin
                    rsp_comb.target       = TGT_ROM;
                    rsp_comb.phys_address = (rom_base
                                             + {8'd0, s1_req_reg.bus_address[13:0]})
                                            & rom_mask_reg;
                end
            end
            OP_RAM_READ:
            begin
                if (ram_ok)
                begin
                    rsp_comb.target       = TGT_RAM;
                    rsp_comb.phys_address = {7'd0, ram_phys};
                end
                else
                begin
                    // disabled or missing ram reads back as 0xff
                    rsp_comb.force_ff = 1'b1;
                end
            end
            OP_RAM_WRITE:
            begin
                if (ram_ok)
                begin
                    rsp_comb.target       = TGT_RAM;
                    rsp_comb.phys_address = {7'd0, ram_phys};
                    rsp_comb.mem_write    = 1'b1;
                    rsp_comb.mem_data     = s1_req_reg.bus_data;
                end
            end
            default:
            begin
                // control writes produce an all-zero result
                rsp_comb = '0;
            end
        endcase
    end

    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = out_rsp_reg;

endmodule
`default_nettype wire

FILE: rtl/core/mbc1_bank_regs.sv
`default_nettype none
module mbc1_bank_regs (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  wr_en,
    input  wire logic [15:0]           bus_address,
    input  wire logic [7:0]            bus_data,
    input  wire mbc1_pkg::mbc_cfg_t    cfg,
    output mbc1_pkg::mbc_state_t       state
);
    import mbc1_pkg::*;

    mbc_state_t  st_reg;
    mbc_state_t  st_next;
    logic [7:0]  rom_sel;
    logic [1:0]  ram_sel;
    logic [1:0]  high_new;
    logic [21:0] rom_a;
    logic [14:0] ram_a;

    always_comb
    begin
        st_next  = st_reg;
        rom_sel  = bus_data;
        ram_sel  = bus_data[1:0];
        high_new = bus_data[1:0];
        rom_a    = '0;
        ram_a    = '0;
        if (wr_en)
        begin
            unique case (bus_address[14:13])
                REGION_RAM_ENABLE:
                begin
                    st_next.ram_enabled = ((bus_data & RAM_ENABLE_KEY) == RAM_ENABLE_KEY);
                end
                REGION_ROM_BANK:
                begin
                    if (bus_data == 8'd1 && bus_address == MULTICART_PROBE_ADDR)
                    begin
                        st_next.multicart_flag = MULTICART_PROBED;
                    end
                    // bank 0 in the low five bits selects the next bank
                    if ((bus_data & ROM_BANK_LOW_MASK) == 8'd0)
                    begin
                        rom_sel = bus_data + 8'd1;
                    end
                    if (rom_sel != st_reg.rom_bank)
                    begin
                        if (st_next.multicart_flag == MULTICART_ACTIVE)
                        begin
                            rom_a = {2'b00, st_reg.rom_high_bits, rom_sel[3:0], 14'd0};
                        end
                        else if (!st_reg.model_select)
                        begin
                            rom_a = {rom_sel, 14'd0} | {1'b0, st_reg.rom_high_bits, 19'd0};
                        end
                        else
                        begin
                            rom_a = {rom_sel, 14'd0};
                        end
                        st_next.rom_bank      = rom_sel;
                        st_next.rom_high_base = rom_a & cfg.rom_mask;
                    end
                end
                REGION_RAM_BANK:
                begin
                    if (st_reg.model_select)
                    begin
                        if (!cfg.ram_present)
                        begin
                            if (st_reg.multicart_flag == MULTICART_ACTIVE)
                            begin
                                // multicart remaps both rom windows
                                rom_a = {2'b00, high_new, 18'd0} & cfg.rom_mask;
                                st_next.rom_high_bits = high_new;
                                st_next.rom_low_base  = rom_a;
                                st_next.rom_high_base = rom_a + ROM_WINDOW_SIZE;
                            end
                            else
                            begin
                                st_next.multicart_flag = MULTICART_NONE;
                            end
                        end
                        if (ram_sel != st_reg.ram_bank)
                        begin
                            ram_a = {ram_sel, 13'd0} & cfg.ram_mask;
                            if (cfg.ram_present)
                            begin
                                st_next.ram_window_base = ram_a;
                            end
                            st_next.ram_bank        = ram_sel;
                            st_next.ram_bank_offset = ram_a;
                            if (st_next.multicart_flag != MULTICART_ACTIVE)
                            begin
                                st_next.rom_high_bits = 2'd0;
                            end
                        end
                    end
                    else
                    begin
                        st_next.rom_high_bits = high_new;
                        st_next.rom_high_base = ({st_reg.rom_bank, 14'd0}
                                                 | {1'b0, high_new, 19'd0}) & cfg.rom_mask;
                        if (cfg.ram_present)
                        begin
                            st_next.ram_window_base = '0;
                        end
                        st_next.ram_bank = 2'd0;
                    end
                end
                REGION_MODEL:
                begin
                    st_next.model_select = bus_data[0];
                    if (bus_data[0])
                    begin
                        ram_a = {st_reg.ram_bank, 13'd0} & cfg.ram_mask;
                        if (cfg.ram_present)
                        begin
                            st_next.ram_window_base = st_reg.ram_bank_offset;
                            st_next.multicart_flag  = MULTICART_NONE;
                        end
                        else
                        begin
                            st_next.multicart_flag = st_reg.multicart_flag | MULTICART_NO_RAM;
                        end
                        st_next.ram_bank_offset = ram_a;
                        st_next.rom_high_base   = {st_reg.rom_bank, 14'd0} & cfg.rom_mask;
                    end
                    else
                    begin
                        st_next.rom_high_base = ({st_reg.rom_bank, 14'd0}
                                                 | {1'b0, st_reg.rom_high_bits, 19'd0})
                                                & cfg.rom_mask;
                        if (cfg.ram_present)
                        begin
                            st_next.ram_window_base = '0;
                        end
                    end
                end
                default:
                begin
                    st_next = st_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= STATE_RESET;
        end
        else
        begin
            st_reg <= st_next;
        end
    end

    assign state = st_reg;

endmodule
`default_nettype wire

FILE: tb/tb_mbc1_bank_controller_top.sv
`default_nettype none
module tb_mbc1_bank_controller_top;
    import mbc1_pkg::*;

    // clocking, reset and run limits
    localparam int CLK_PERIOD       = 10;
    localparam int RESET_CYCLES     = 4;
    localparam int CYCLE_LIMIT      = 400000;
    // idle time after the last owed result, so the block settles
    localparam int SETTLE_CYCLES    = 4;
    localparam int LONG_HOLD_CYCLES = 200;
    localparam int PHASE_ACCESSES   = 300;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    mbc1_stream_if #(.payload_t(mbc_req_t)) req_if ();
    mbc1_stream_if #(.payload_t(mbc_rsp_t)) rsp_if ();

    mbc1_bank_controller_top u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_if),
        .rsp     (rsp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // predicted cartridge state and register settings
    mbc_state_t bank_state = STATE_RESET;
    mbc_cfg_t   cart_cfg = '{rom_mask: ROM_MASK_RESET, ram_mask: RAM_MASK_RESET,
                             ram_present: RAM_PRESENT_RESET};

    // translations still owed by the block, oldest first
    mbc_rsp_t pending_translations[$];

    int mismatches       = 0;
    int accesses_sent    = 0;
    int results_checked  = 0;
    int cycle_count      = 0;
    int settings_applied = 0;

    // idling controls shared by the sender and the receiver process
    bit sender_idles   = 1'b1;
    bit receiver_idles = 1'b1;
    bit hold_receiver  = 1'b0;

    // data bytes that hit the bank quirks: bank 0, enable key, probe value, mode bits
    logic [7:0] special_bytes [8] = '{8'h00, 8'h01, 8'h0A, 8'h1F, 8'h20, 8'h60, 8'h03, 8'hFF};

    // bank controller prediction: updates the bank state on control writes and
    // returns the translation that one bus access produces
    function automatic mbc_rsp_t translate_access(input mbc_req_t acc);
        mbc_rsp_t    res;
        logic [31:0] addr;
        logic [31:0] data;
        logic [31:0] a;
        logic [31:0] ram_phys;
        logic [1:0]  bank2;
        res = '0;
        addr = 32'(acc.bus_address);
        data = 32'(acc.bus_data);
        ram_phys = (32'(bank_state.ram_window_base) + (addr & 32'h1FFF))
                   & 32'(cart_cfg.ram_mask);
        case (acc.operation)
            OP_CTRL_WRITE:
            begin
                // writes at or above 0x8000 never reach the control registers
                if (addr < 32'h8000)
                begin
                    case (acc.bus_address[14:13])
                        REGION_RAM_ENABLE:
                            bank_state.ram_enabled = ((data[7:0] & RAM_ENABLE_KEY) == RAM_ENABLE_KEY);
                        REGION_ROM_BANK:
                        begin
                            if (data == 32'd1 && acc.bus_address == MULTICART_PROBE_ADDR)
                                bank_state.multicart_flag = MULTICART_PROBED;
                            // bank 0 in the low five bits selects the next bank
                            if ((data[7:0] & ROM_BANK_LOW_MASK) == 8'h00)
                                data = (data + 32'd1) & 32'hFF;
                            // the same bank again leaves the bank and the high window alone
                            if (data[7:0] != bank_state.rom_bank)
                            begin
                                if (bank_state.multicart_flag == MULTICART_ACTIVE)
                                    a = ((data & 32'hF) << 14)
                                        | (32'(bank_state.rom_high_bits) << 18);
                                else
                                begin
                                    a = data << 14;
                                    if (!bank_state.model_select)
                                        a = a | (32'(bank_state.rom_high_bits) << 19);
                                end
                                bank_state.rom_bank = data[7:0];
                                bank_state.rom_high_base = 22'(a & 32'(cart_cfg.rom_mask));
                            end
                        end
                        REGION_RAM_BANK:
                        begin
                            if (bank_state.model_select)
                            begin
                                if (!cart_cfg.ram_present)
                                begin
                                    if (bank_state.multicart_flag == MULTICART_ACTIVE)
                                    begin
                                        bank_state.rom_high_bits = data[1:0];
                                        a = (32'(data[1:0]) << 18) & 32'(cart_cfg.rom_mask);
                                        bank_state.rom_low_base = 22'(a);
                                        bank_state.rom_high_base = 22'(a + 32'(ROM_WINDOW_SIZE));
                                    end
                                    else
                                        bank_state.multicart_flag = MULTICART_NONE;
                                end
                                bank2 = data[1:0];
                                if (bank2 != bank_state.ram_bank)
                                begin
                                    a = (32'(bank2) << 13) & 32'(cart_cfg.ram_mask);
                                    if (cart_cfg.ram_present)
                                        bank_state.ram_window_base = 15'(a);
                                    bank_state.ram_bank = bank2;
                                    bank_state.ram_bank_offset = 15'(a);
                                    if (bank_state.multicart_flag != MULTICART_ACTIVE)
                                        bank_state.rom_high_bits = 2'd0;
                                end
                            end
                            else
                            begin
                                bank_state.rom_high_bits = data[1:0];
                                a = (32'(bank_state.rom_bank) << 14)
                                    | (32'(bank_state.rom_high_bits) << 19);
                                bank_state.rom_high_base = 22'(a & 32'(cart_cfg.rom_mask));
                                if (cart_cfg.ram_present)
                                    bank_state.ram_window_base = 15'd0;
                                bank_state.ram_bank = 2'd0;
                            end
                        end
                        REGION_MODEL:
                        begin
                            bank_state.model_select = data[0];
                            if (bank_state.model_select)
                            begin
                                bank2 = bank_state.ram_bank;
                                a = (32'(bank2) << 13) & 32'(cart_cfg.ram_mask);
                                // the window takes the offset held before this write
                                if (cart_cfg.ram_present)
                                begin
                                    bank_state.ram_window_base = bank_state.ram_bank_offset;
                                    bank_state.multicart_flag = MULTICART_NONE;
                                end
                                else
                                    bank_state.multicart_flag = bank_state.multicart_flag
                                                                | MULTICART_NO_RAM;
                                bank_state.ram_bank = bank2;
                                bank_state.ram_bank_offset = 15'(a);
                                bank_state.rom_high_base =
                                    22'((32'(bank_state.rom_bank) << 14) & 32'(cart_cfg.rom_mask));
                            end
                            else
                            begin
                                a = (32'(bank_state.rom_bank) << 14)
                                    | (32'(bank_state.rom_high_bits) << 19);
                                bank_state.rom_high_base = 22'(a & 32'(cart_cfg.rom_mask));
                                if (cart_cfg.ram_present)
                                    bank_state.ram_window_base = 15'd0;
                            end
                        end
                    endcase
                end
            end
            OP_ROM_READ:
            begin
                if (addr < 32'h4000)
                begin
                    res.target = TGT_ROM;
                    res.phys_address = 22'((32'(bank_state.rom_low_base) + addr)
                                           & 32'(cart_cfg.rom_mask));
                end
                else if (addr < 32'h8000)
                begin
                    res.target = TGT_ROM;
                    res.phys_address = 22'((32'(bank_state.rom_high_base) + (addr & 32'h3FFF))
                                           & 32'(cart_cfg.rom_mask));
                end
            end
            OP_RAM_READ:
            begin
                if (bank_state.ram_enabled && cart_cfg.ram_present)
                begin
                    res.target = TGT_RAM;
                    res.phys_address = 22'(ram_phys);
                end
                else
                    res.force_ff = 1'b1;
            end
            OP_RAM_WRITE:
            begin
                // a write with ram off or absent is simply dropped
                if (bank_state.ram_enabled && cart_cfg.ram_present)
                begin
                    res.target = TGT_RAM;
                    res.phys_address = 22'(ram_phys);
                    res.mem_write = 1'b1;
                    res.mem_data = acc.bus_data;
                end
            end
        endcase
        return res;
    endfunction

    function automatic mbc_req_t bus_access(input op_t op, input logic [15:0] addr,
                                            input logic [7:0] data);
        mbc_req_t acc;
        acc.operation = op;
        acc.bus_address = addr;
        acc.bus_data = data;
        return acc;
    endfunction

    // random access, weighted toward control writes and in-range windows
    function automatic mbc_req_t random_access();
        mbc_req_t acc;
        int       pick;
        pick = $urandom_range(0, 99);
        acc.bus_data = ($urandom_range(0, 3) == 0) ? special_bytes[$urandom_range(0, 7)]
                                                   : 8'($urandom);
        if (pick < 40)
        begin
            acc.operation = OP_CTRL_WRITE;
            case ($urandom_range(0, 9))
                0:
                begin
                    acc.bus_address = MULTICART_PROBE_ADDR;
                    if ($urandom_range(0, 1) == 0)
                        acc.bus_data = 8'h01;
                end
                1:       acc.bus_address = 16'h8000 | 16'($urandom);
                default: acc.bus_address = 16'($urandom_range(0, 16'h7FFF));
            endcase
        end
        else if (pick < 70)
        begin
            acc.operation = OP_ROM_READ;
            acc.bus_address = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                          : 16'($urandom_range(0, 16'h7FFF));
        end
        else
        begin
            acc.operation = (pick < 85) ? OP_RAM_READ : OP_RAM_WRITE;
            acc.bus_address = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                          : 16'h A000 + 16'($urandom_range(0, 16'h1FFF));
        end
        return acc;
    endfunction

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    // scoreboard: predict on every accepted access, then check every accepted result
    always @(posedge clk)
    begin : scoreboard
        mbc_rsp_t want;
        mbc_rsp_t got;
        if (rst_n)
        begin
            if (req_if.valid && req_if.ready)
                pending_translations.push_back(translate_access(req_if.payload));
            if (rsp_if.valid && rsp_if.ready)
            begin
                got = rsp_if.payload;
                if (pending_translations.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result, expected none, actual %h", $time, got);
                end
                else
                begin
                    want = pending_translations.pop_front();
                    results_checked++;
                    compare_field("target", want.target, got.target);
                    compare_field("phys_address", want.phys_address, got.phys_address);
                    compare_field("mem_write", want.mem_write, got.mem_write);
                    compare_field("mem_data", want.mem_data, got.mem_data);
                    compare_field("force_ff", want.force_ff, got.force_ff);
                end
            end
        end
    end

    // watchdog on total run length
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still owed", cycle_count,
                     pending_translations.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // receiver: random ready bursts, a long hold on request, steady ready when idling is off
    initial
    begin
        rsp_if.ready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_receiver)
            begin
                rsp_if.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                hold_receiver = 1'b0;
            end
            else if (receiver_idles && $urandom_range(0, 3) == 0)
            begin
                rsp_if.ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            else
            begin
                rsp_if.ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge clk);
            end
        end
    end

    task automatic pause_sender(input int cycles);
        req_if.valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // offer one access and hold it until the block takes the transaction
    task automatic send_access(input mbc_req_t acc);
        req_if.valid <= 1'b1;
        req_if.payload <= acc;
        do
            @(posedge clk);
        while (!req_if.ready);
        accesses_sent++;
        if (sender_idles && $urandom_range(0, 5) == 0)
            pause_sender($urandom_range(1, 12));
    endtask

    // stop offering until every owed result is back, then let the block settle
    task automatic drain_results();
        req_if.valid <= 1'b0;
        @(posedge clk);
        while (pending_translations.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // apb write of one register, followed by a read back of the kept bits
    task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
        logic [31:0] kept;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            REG_ROM_MASK:    cart_cfg.rom_mask = value[21:0];
            REG_RAM_MASK:    cart_cfg.ram_mask = value[14:0];
            REG_RAM_PRESENT: cart_cfg.ram_present = value[0];
            default:         ;
        endcase
        case (idx)
            REG_ROM_MASK:    kept = 32'(cart_cfg.rom_mask);
            REG_RAM_MASK:    kept = 32'(cart_cfg.ram_mask);
            default:         kept = 32'(cart_cfg.ram_present);
        endcase
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        compare_field("register readback", kept, prdata);
        psel <= 1'b0;
        penable <= 1'b0;
        // leave the bus idle before the next transfer
        @(posedge clk);
    endtask

    task automatic apply_setting(input logic [31:0] rom_mask, input logic [31:0] ram_mask,
                                 input logic [31:0] present);
        drain_results();
        write_register(REG_ROM_MASK, rom_mask);
        write_register(REG_RAM_MASK, ram_mask);
        write_register(REG_RAM_PRESENT, present);
        settings_applied++;
    endtask

    // reset windows, bank 0 remap, unchanged bank, ram gating, out-of-range addresses
    task automatic test_directed_accesses();
        send_access(bus_access(OP_ROM_READ, 16'h0000, 8'h00));
        send_access(bus_access(OP_ROM_READ, 16'h7FFF, 8'hFF));
        send_access(bus_access(OP_ROM_READ, 16'h8000, 8'h00));
        send_access(bus_access(OP_ROM_READ, 16'hFFFF, 8'h00));
        send_access(bus_access(OP_RAM_READ, 16'hA000, 8'h00));
        send_access(bus_access(OP_RAM_WRITE, 16'hA001, 8'h55));
        send_access(bus_access(OP_CTRL_WRITE, 16'h0000, RAM_ENABLE_KEY));
        send_access(bus_access(OP_RAM_WRITE, 16'hBFFF, 8'hFF));
        send_access(bus_access(OP_RAM_READ, 16'hA123, 8'h00));
        send_access(bus_access(OP_RAM_READ, 16'h1234, 8'h00));
        send_access(bus_access(OP_CTRL_WRITE, 16'h2000, 8'h00));
        send_access(bus_access(OP_CTRL_WRITE, 16'h3FFF, 8'h1F));
        send_access(bus_access(OP_ROM_READ, 16'h4000, 8'h00));
        send_access(bus_access(OP_CTRL_WRITE, 16'h4000, 8'h03));
        send_access(bus_access(OP_ROM_READ, 16'h5555, 8'h00));
        send_access(bus_access(OP_CTRL_WRITE, 16'h6000, 8'h01));
        send_access(bus_access(OP_CTRL_WRITE, 16'h5FFF, 8'h02));
        send_access(bus_access(OP_RAM_READ, 16'hA000, 8'h00));
        send_access(bus_access(OP_CTRL_WRITE, 16'h8000, 8'hFF));
        send_access(bus_access(OP_CTRL_WRITE, 16'hFFFF, 8'h0A));
        send_access(bus_access(OP_CTRL_WRITE, 16'h1FFF, 8'h00));
        send_access(bus_access(OP_RAM_READ, 16'hA000, 8'h00));
        send_access(bus_access(OP_CTRL_WRITE, 16'h7FFF, 8'h00));
    endtask

    // multicart remap: probe write, then mode 1 without ram arms the remapping
    task automatic test_multicart_remap();
        apply_setting(32'h003F_FFFF, 32'h0000_1FFF, 32'd0);
        send_access(bus_access(OP_CTRL_WRITE, MULTICART_PROBE_ADDR, 8'h01));
        send_access(bus_access(OP_CTRL_WRITE, 16'h6000, 8'h01));
        send_access(bus_access(OP_CTRL_WRITE, 16'h4000, 8'h02));
        send_access(bus_access(OP_ROM_READ, 16'h0000, 8'h00));
        send_access(bus_access(OP_ROM_READ, 16'h4000, 8'h00));
        send_access(bus_access(OP_CTRL_WRITE, 16'h2000, 8'h15));
        send_access(bus_access(OP_ROM_READ, 16'h7FFF, 8'h00));
        send_access(bus_access(OP_CTRL_WRITE, 16'h0000, RAM_ENABLE_KEY));
        send_access(bus_access(OP_RAM_READ, 16'hA000, 8'h00));
        send_access(bus_access(OP_RAM_WRITE, 16'hA000, 8'hAA));
        send_access(bus_access(OP_CTRL_WRITE, 16'h4000, 8'h01));
        send_access(bus_access(OP_CTRL_WRITE, 16'h6000, 8'h00));
    endtask

    // long receiver hold while the sender keeps offering, so the input stalls
    task automatic test_input_backpressure();
        drain_results();
        sender_idles = 1'b0;
        hold_receiver = 1'b1;
        repeat (60) send_access(random_access());
        sender_idles = 1'b1;
        // sender waits here for every owed result
        drain_results();
    endtask

    // random phases over several register settings, the extremes among them
    task automatic test_random_phases();
        logic [31:0] rom_masks [6] = '{32'h0000_7FFF, 32'h003F_FFFF, 32'h0000_0000,
                                       32'h001F_FFFF, 32'hFFFF_FFFF, 32'h0000_0000};
        logic [31:0] ram_masks [6] = '{32'h0000_1FFF, 32'h0000_7FFF, 32'h0000_0000,
                                       32'h0000_7FFF, 32'hFFFF_FFFF, 32'h0000_0000};
        logic [31:0] presents  [6] = '{32'd1, 32'd1, 32'd1, 32'd0, 32'hFFFF_FFFE, 32'd1};
        for (int p = 0; p < 6; p++)
        begin
            if (p == 5)
            begin
                rom_masks[p] = $urandom;
                ram_masks[p] = $urandom;
                presents[p] = $urandom;
            end
            apply_setting(rom_masks[p], ram_masks[p], presents[p]);
            // one phase runs with no idling on either side
            sender_idles = (p != 2);
            receiver_idles = (p != 2);
            repeat (PHASE_ACCESSES) send_access(random_access());
        end
        sender_idles = 1'b1;
        receiver_idles = 1'b1;
    endtask

    // closing stretch at full rate with no idling anywhere
    task automatic test_steady_stream();
        apply_setting(32'h003F_FFFF, 32'h0000_7FFF, 32'd1);
        sender_idles = 1'b0;
        receiver_idles = 1'b0;
        repeat (100) send_access(random_access());
    endtask

    initial
    begin
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        req_if.valid <= 1'b0;
        req_if.payload <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_accesses();
        test_multicart_remap();
        test_input_backpressure();
        test_random_phases();
        test_steady_stream();
        drain_results();

        $display("covered %0d bus accesses, %0d results checked, %0d register settings",
                 accesses_sent, results_checked, settings_applied);
        $display("areas: reset windows, bank quirks, multicart remap, stalls, random phases");
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
`default_nettype wire
